>>> rtl/ilt_pkg.sv
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int IDX_W   = 7;

    // found_index when nothing matched
    localparam logic [IDX_W-1:0] IDX_NONE = {IDX_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/ilt_if.sv
`timescale 1ns / 1ps

interface ilt_in_if;
    logic                        valid;
    logic                        ready;
    logic [ilt_pkg::MODE_W-1:0]  mode;
    logic [ilt_pkg::VALUE_W-1:0] value;
    logic [ilt_pkg::POS_W-1:0]   position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ilt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [ilt_pkg::IDX_W-1:0]   found_index;
    logic [ilt_pkg::VALUE_W-1:0] read_value;
    logic [ilt_pkg::IDX_W-1:0]   count_after;

    modport source (output valid, ok, found_index, read_value, count_after, input ready);
    modport sink   (input valid, ok, found_index, read_value, count_after, output ready);
endinterface

>>> rtl/ilt_cell.sv
`timescale 1ns / 1ps

module ilt_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [ilt_pkg::VALUE_W-1:0] i_d,
    output logic [ilt_pkg::VALUE_W-1:0] o_q
);
    import ilt_pkg::*;

    logic [VALUE_W-1:0] r_q;

    // one entry; loads i_d on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/indexed_list_table_core.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH unsigned 32-bit values with append, find, read
// and delete-with-compaction. The entries live in a ring of DEPTH cells; a
// request turns the ring once, one cell per cycle, so entry k sits at the
// head cell in scan step k. Find and read watch the head as it passes,
// append drops the new value into the ring at the step equal to the count,
// and delete feeds the ring from the second cell from the doomed position
// onwards, which closes the gap in the same turn. A request is not accepted
// while the previous one is still scanning or handing over its response;
// the next request is taken in the cycle after the response is loaded.
// A finished response waits in its own register; the block then accepts
// the next request while it is still held. count_after and found_index
// are the low seven bits of the count and position. No clearing after
// reset: only entries below the count are ever observed.
module indexed_list_table_core #(
    parameter int DEPTH = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ilt_in_if.sink    i_req,
    ilt_out_if.source o_rsp
);
    import ilt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int STP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // common width for position/count/step compares
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [STP_W-1:0] STEP_LAST = STP_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    // ring of cells
    logic [VALUE_W-1:0] w_q [DEPTH];
    logic [VALUE_W-1:0] w_tail;
    logic [VALUE_W-1:0] w_next;
    logic               w_shift;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_W-1:0] w_d;
            if (g == DEPTH - 1) begin : g_tail
                assign w_d = w_tail;
            end else begin : g_link
                assign w_d = w_q[g + 1];
            end
            ilt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_d),
                .o_q     (w_q[g])
            );
        end
        // entry after the head, used to close the gap on delete
        if (DEPTH > 1) begin : g_next
            assign w_next = w_q[1];
        end else begin : g_next_one
            assign w_next = w_q[0];
        end
    endgenerate

    // sequencer state
    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [STP_W-1:0]   r_step,   n_step;
    t_mode              r_mode,   n_mode;
    logic [VALUE_W-1:0] r_value,  n_value;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic               r_ok,     n_ok;     // append/read/delete verdict
    logic               r_hit,    n_hit;    // find matched
    logic [IDX_W-1:0]   r_found,  n_found;
    logic [VALUE_W-1:0] r_rd,     n_rd;

    // response register
    logic               r_ovalid, n_ovalid;
    logic               r_ook,    n_ook;
    logic [IDX_W-1:0]   r_ofound, n_ofound;
    logic [VALUE_W-1:0] r_ord,    n_ord;
    logic [IDX_W-1:0]   r_ocount, n_ocount;

    logic w_accept;
    logic w_load;
    logic [CMP_W-1:0] w_step_x, w_pos_x, w_cnt_x;
    logic [CMP_W-1:0] w_in_pos_x;
    logic [VALUE_W-1:0] w_head;

    assign w_head     = w_q[0];
    assign w_step_x   = CMP_W'(r_step);
    assign w_pos_x    = CMP_W'(r_pos);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_in_pos_x = CMP_W'(i_req.position);

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_mode   = r_mode;
        n_value  = r_value;
        n_pos    = r_pos;
        n_ok     = r_ok;
        n_hit    = r_hit;
        n_found  = r_found;
        n_rd     = r_rd;
        w_shift  = 1'b0;
        w_tail   = w_head;
        w_load   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode  = t_mode'(i_req.mode);
                    n_value = i_req.value;
                    n_pos   = i_req.position;
                    n_step  = '0;
                    n_hit   = 1'b0;
                    n_found = IDX_NONE;
                    n_rd    = '0;
                    if (t_mode'(i_req.mode) == MODE_APPEND) begin
                        n_ok = (r_count < CNT_FULL);
                    end else begin
                        n_ok = (w_in_pos_x < w_cnt_x);
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_shift = 1'b1;
                case (r_mode)
                    MODE_APPEND: begin
                        if (r_ok && (w_step_x == w_cnt_x)) begin
                            w_tail = r_value;
                        end
                    end
                    MODE_FIND: begin
                        if (!r_hit && (w_step_x < w_cnt_x) && (w_head == r_value)) begin
                            n_hit   = 1'b1;
                            n_found = IDX_W'(r_step);
                        end
                    end
                    MODE_READ: begin
                        if (r_ok && (w_step_x == w_pos_x)) begin
                            n_rd = w_head;
                        end
                    end
                    MODE_DELETE: begin
                        if (r_ok && (w_step_x >= w_pos_x)) begin
                            w_tail = w_next;
                        end
                    end
                    default: ;
                endcase
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    if (r_ok && (r_mode == MODE_APPEND)) begin
                        n_count = r_count + 1'b1;
                    end else if (r_ok && (r_mode == MODE_DELETE)) begin
                        n_count = r_count - 1'b1;
                    end
                    n_step  = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // response register
    always_comb begin
        n_ovalid = r_ovalid;
        n_ook    = r_ook;
        n_ofound = r_ofound;
        n_ord    = r_ord;
        n_ocount = r_ocount;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        if (w_load) begin
            n_ovalid = 1'b1;
            n_ook    = (r_mode == MODE_FIND) ? r_hit : r_ok;
            n_ofound = r_found;
            n_ord    = r_rd;
            n_ocount = IDX_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_ok     <= n_ok;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_rd     <= n_rd;
        r_ook    <= n_ook;
        r_ofound <= n_ofound;
        r_ord    <= n_ord;
        r_ocount <= n_ocount;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.ok          = r_ook;
    assign o_rsp.found_index = r_ofound;
    assign o_rsp.read_value  = r_ord;
    assign o_rsp.count_after = r_ocount;

endmodule

>>> rtl/ilt_checker.sv
`timescale 1ns / 1ps

module ilt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_ok,
    input  logic [ilt_pkg::IDX_W-1:0]   i_found_index,
    input  logic [ilt_pkg::VALUE_W-1:0] i_read_value,
    input  logic [ilt_pkg::IDX_W-1:0]   i_count_after
);
    import ilt_pkg::*;

    // a held response keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_ok) && $stable(i_found_index) &&
            $stable(i_read_value) && $stable(i_count_after))
        else $error("response changed while stalled");

    // one request at a time: the scan follows every accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted during a scan");

    // a reported position always comes with success
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_found_index != IDX_NONE) |-> i_ok)
        else $error("found_index without ok");

    // a failed request reports no position and no data
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> (i_found_index == IDX_NONE) && (i_read_value == '0))
        else $error("failed request carries data");

endmodule

bind indexed_list_table_core ilt_checker u_ilt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_ok          (o_rsp.ok),
    .i_found_index (o_rsp.found_index),
    .i_read_value  (o_rsp.read_value),
    .i_count_after (o_rsp.count_after)
);
